// ===== rtl/sid_pkg.sv =====
package sid_pkg;

  // Default width of the signed input value
  localparam int VALUE_WIDTH_DEF = 32;

  // One BCD digit
  localparam int DIGIT_BITS = 4;

  // ASCII codes
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_STRIP,
    ST_EMIT
  } sid_state_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII text.
//
// Input channel: item_valid / item_ready with value, a signed two's complement
// integer of VALUE_WIDTH bits. Output channel: result_valid / result_ready with
// character (an ASCII '-' or '0'..'9') and last, high on the final character of
// one number's text. Characters leave most significant first, with no leading
// zeros; zero gives a single '0', and the most negative value converts exactly.
//
// Timing: an item is taken only while the unit is idle and its output register
// is free. A negative sign is loaded into the output register at acceptance.
// A shared add-three-and-shift unit then runs once per input bit, leading zero
// digits are dropped one per cycle, and one digit leaves per cycle while the
// receiver is ready. A new item is taken only after the last digit of the one
// before has been loaded into the output register, so the pace is set by the
// serial binary-to-BCD loop and the digit scan.
//
// Reset clears the sequencer and the output valid flag; no result is pending.
// While the receiver stalls, the current character is held and the sequencer
// waits in its emit state; nothing is lost or repeated.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = sid_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [7:0]                    character,
  output logic                          last
);
  import sid_pkg::*;

  // Enough BCD digits for 2^VALUE_WIDTH (log10(2) ~ 1233/4096)
  localparam int NDIG      = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BCD_W     = NDIG * DIGIT_BITS;
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W = $clog2(NDIG + 1);

  localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(VALUE_WIDTH - 1);
  localparam logic [DIG_CNT_W-1:0] DIG_CNT_INIT = DIG_CNT_W'(NDIG);
  localparam logic [DIG_CNT_W-1:0] DIG_CNT_ONE  = DIG_CNT_W'(1);

  sid_state_t             state, state_next;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_step;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_cnt;

  logic [DIGIT_BITS-1:0]  top_digit;
  logic                   slot_free;
  logic                   item_take;
  logic                   value_neg;
  logic [VALUE_WIDTH-1:0] value_mag;
  logic                   strip_more;
  logic                   do_step;
  logic                   do_strip;
  logic                   do_emit;

  assign top_digit  = bcd[BCD_W-1 -: DIGIT_BITS];
  assign slot_free  = !result_valid || result_ready;
  assign item_take  = item_valid && item_ready;
  assign value_neg  = value[VALUE_WIDTH-1];
  // Unsigned magnitude; the most negative value wraps to 2^(VALUE_WIDTH-1)
  assign value_mag  = value_neg ? (~$unsigned(value) + VALUE_WIDTH'(1)) : $unsigned(value);
  assign strip_more = (top_digit == '0) && (dig_cnt != DIG_CNT_ONE);

  // Shared add-three-and-shift unit
  sid_dabble_step #(
    .NDIG (NDIG)
  ) u_step (
    .bcd_in  (bcd),
    .bit_in  (mag[VALUE_WIDTH-1]),
    .bcd_out (bcd_step)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_take) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (bit_cnt == BIT_CNT_LAST) state_next = ST_STRIP;
      end
      ST_STRIP: begin
        if (!strip_more) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && dig_cnt == DIG_CNT_ONE) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_ready = 1'b0;
    do_step    = 1'b0;
    do_strip   = 1'b0;
    do_emit    = 1'b0;
    unique case (state)
      ST_IDLE:    item_ready = slot_free;
      ST_CONVERT: do_step    = 1'b1;
      ST_STRIP:   do_strip   = strip_more;
      ST_EMIT:    do_emit    = slot_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((item_take && value_neg) || do_emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath: magnitude, BCD accumulator, counters and output character
  always_ff @(posedge clk) begin
    if (item_take) begin
      mag     <= value_mag;
      bcd     <= '0;
      bit_cnt <= '0;
      dig_cnt <= DIG_CNT_INIT;
      if (value_neg) begin
        character <= CHAR_MINUS;
        last      <= 1'b0;
      end
    end else if (do_step) begin
      mag     <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bcd     <= bcd_step;
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end else if (do_strip) begin
      bcd     <= {bcd[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
      dig_cnt <= dig_cnt - DIG_CNT_ONE;
    end else if (do_emit) begin
      character <= CHAR_ZERO + {{(8-DIGIT_BITS){1'b0}}, top_digit};
      last      <= (dig_cnt == DIG_CNT_ONE);
      bcd       <= {bcd[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
      dig_cnt   <= dig_cnt - DIG_CNT_ONE;
    end
  end

`ifndef SYNTHESIS
  a_take_starts_convert: assert property (@(posedge clk) disable iff (rst)
    item_take |=> (state == ST_CONVERT) && (bit_cnt == '0))
    else $error("accepted item did not start conversion");

  a_final_digit_flagged: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && slot_free && dig_cnt == DIG_CNT_ONE)
      |=> (state == ST_IDLE) && result_valid && last)
    else $error("final digit not flagged or sequencer not idle");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT || state == ST_STRIP) |-> (dig_cnt != '0))
    else $error("digit count exhausted while emitting");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && character == CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as last character");
`endif

endmodule

// ===== rtl/sid_dabble_step.sv =====
module sid_dabble_step #(
  parameter int NDIG = 10
) (
  input  logic [NDIG*sid_pkg::DIGIT_BITS-1:0] bcd_in,
  input  logic                                bit_in,
  output logic [NDIG*sid_pkg::DIGIT_BITS-1:0] bcd_out
);
  import sid_pkg::*;

  logic [NDIG*DIGIT_BITS-1:0] adj;

  // Add three to every digit of five or more, then shift one binary bit in
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_in[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
        adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_in[i*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
      end else begin
        adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_in[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  assign bcd_out = {adj[NDIG*DIGIT_BITS-2:0], bit_in};

endmodule
